@@ rtl/core/silence_segmented_amplitude_histogram_assert.svh @@
// ----------------------------------------------------------------------------
// histogram block assertion macros
// short wrappers for concurrent checks with a common clock and reset
// ----------------------------------------------------------------------------
`ifndef SILENCE_SEGMENTED_AMPLITUDE_HISTOGRAM_ASSERT_SVH
`define SILENCE_SEGMENTED_AMPLITUDE_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define SSAH_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SSAH_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/ssah_pkg.sv @@
// ----------------------------------------------------------------------------
// ssah_pkg
// shared types and constants of the silence-segmented amplitude histogram
// ----------------------------------------------------------------------------
`default_nettype none

package ssah_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int SILENCE_W   = 16;
   localparam int START_W     = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int SEG_OUT_W   = 2;
   localparam int BIN_W       = 4;
   localparam int NUM_BINS    = 10;

   localparam int DEF_SEGMENTS    = 4;
   localparam int DEF_FRAC_BITS   = 28;
   localparam int DEF_COUNT_WIDTH = 16;

   localparam logic [SILENCE_W-1:0] SILENCE_RESET = 16'd150;
   localparam logic [START_W-1:0]   START_RESET   = 3'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SILENCE_RUN   = 1'b0,
      CSR_START_SEGMENT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROC,
      ST_WB,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   // reduced sample as seen by the control logic
   typedef struct packed {
      logic             zero;
      logic             hit;
      logic [BIN_W-1:0] bin;
   } red_type;

   // commands to the count store
   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } mem_cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/ssah_reduce.sv @@
// ----------------------------------------------------------------------------
// ssah_reduce
// rounds, clips and scales a fixed-point sample to -128..127 and picks its bin
// ----------------------------------------------------------------------------
`default_nettype none

module ssah_reduce #(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                               clock,
   input  wire logic                               load,
   input  wire logic signed [ssah_pkg::SAMPLE_W-1:0] sample,
   output ssah_pkg::red_type                       result
);
   import ssah_pkg::*;

   localparam int SHIFT = FRAC_BITS - 15;
   localparam logic signed [SAMPLE_W:0] ONE_VAL  = 33'sd1 <<< FRAC_BITS;
   localparam logic signed [SAMPLE_W:0] HALF_LSB = 33'sd1 <<< (FRAC_BITS - 16);

   logic signed [SAMPLE_W:0] sum;
   logic signed [SAMPLE_W:0] clip;
   logic signed [15:0]       shifted;
   logic        [16:0]       adj;
   logic signed [7:0]        q;
   red_type                  result_in;
   red_type                  result_ff;

   always_comb begin
      sum = $signed({sample[SAMPLE_W-1], sample}) + HALF_LSB;
      if (sum >= ONE_VAL) begin
         clip = ONE_VAL - 33'sd1;
      end else if (sum < -ONE_VAL) begin
         clip = -ONE_VAL;
      end else begin
         clip = sum;
      end
      shifted = 16'(clip >>> SHIFT);
      // divide by 256 towards zero: bias negatives before the floor shift
      adj = {shifted[15], shifted} + (shifted[15] ? 17'd255 : 17'd0);
      q   = $signed(adj[15:8]);

      result_in.zero = (q == 8'sd0);
      result_in.hit  = 1'b1;
      if (q >= 8'sd120) begin
         result_in.bin = 4'd0;
      end else if (q >= 8'sd96) begin
         result_in.bin = 4'd1;
      end else if (q >= 8'sd64) begin
         result_in.bin = 4'd2;
      end else if (q >= 8'sd32) begin
         result_in.bin = 4'd3;
      end else if (q >= 8'sd16) begin
         result_in.bin = 4'd4;
      end else if (q <= -8'sd120) begin
         result_in.bin = 4'd9;
      end else if (q <= -8'sd96) begin
         result_in.bin = 4'd8;
      end else if (q <= -8'sd64) begin
         result_in.bin = 4'd7;
      end else if (q <= -8'sd32) begin
         result_in.bin = 4'd6;
      end else if (q <= -8'sd16) begin
         result_in.bin = 4'd5;
      end else begin
         result_in.bin = 4'd0;
         result_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ rtl/core/ssah_count_mem.sv @@
// ----------------------------------------------------------------------------
// ssah_count_mem
// count store: one read and one write port, registered read, per-entry valid
// ----------------------------------------------------------------------------
`default_nettype none

module ssah_count_mem #(
   parameter int DEPTH = 40,
   parameter int WIDTH = 16,
   parameter int ADDR_W = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ssah_pkg::mem_cmd_type      cmd,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   output logic      [WIDTH-1:0]           rd_data
);
   import ssah_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // an entry never written since the last clear reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/silence_segmented_amplitude_histogram.sv @@
// Latency: an item is taken, then processed in the next cycle; an item that
// updates a counter then passes through ST_WB for the read-modify-write.
// Items: ST_IDLE, ST_PROC, plus ST_WB to update a counter (count store port);
// a new item is taken only in ST_IDLE. Emission: SEGMENTS*10 results, each in
// ST_EMIT_RD then ST_EMIT_OUT (held by output stall); no item meanwhile.
// Reset: synchronous; counters read as zero at once, no clearing pass.
`default_nettype none

module silence_segmented_amplitude_histogram #(
   parameter int SEGMENTS    = ssah_pkg::DEF_SEGMENTS,
   parameter int FRAC_BITS   = ssah_pkg::DEF_FRAC_BITS,
   parameter int COUNT_WIDTH = ssah_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [ssah_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [ssah_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [ssah_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                                  req_end_of_stream,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [ssah_pkg::SEG_OUT_W-1:0]             rsp_segment,
   output logic [ssah_pkg::BIN_W-1:0]                 rsp_bin,
   output logic [COUNT_WIDTH-1:0]                     rsp_count,
   output logic                                       rsp_last_count
);
   import ssah_pkg::*;

   localparam int TOTAL  = SEGMENTS * NUM_BINS;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int SW     = $clog2(SEGMENTS + 1) + 2;
   localparam logic signed [SW-1:0] SEG_LIMIT = SW'(SEGMENTS);
   localparam logic signed [SW-1:0] SEG_LAST  = SW'(SEGMENTS - 1);
   localparam logic [ADDR_W-1:0]    ADDR_LAST = ADDR_W'(TOTAL - 1);
   localparam logic [BIN_W-1:0]     BIN_LAST  = BIN_W'(NUM_BINS - 1);

   state_type               state_ff, state_in;
   logic [SILENCE_W-1:0]    silence_run_ff, silence_run_in;
   logic [START_W-1:0]      start_seg_ff, start_seg_in;
   logic [SILENCE_W-1:0]    zero_run_ff, zero_run_in;
   logic                    in_gap_ff, in_gap_in;
   logic signed [SW-1:0]    seg_ff, seg_in;
   logic                    finished_ff, finished_in;
   logic                    eos_ff, eos_in;
   logic                    gap_emit_ff, gap_emit_in;
   logic [ADDR_W-1:0]       emit_addr_ff, emit_addr_in;
   logic [SEG_OUT_W-1:0]    emit_seg_ff, emit_seg_in;
   logic [BIN_W-1:0]        emit_bin_ff, emit_bin_in;
   logic [ADDR_W-1:0]       wb_addr_ff, wb_addr_in;

   logic                    accept;
   red_type                 red;
   mem_cmd_type             mem_cmd;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [COUNT_WIDTH-1:0]  mem_rd_data;
   logic [COUNT_WIDTH-1:0]  mem_wr_data;

   logic [SILENCE_W-1:0]    zr_new;
   logic                    gap_new;
   logic                    seg_ok;
   logic                    count_go;
   logic                    gap_go;
   logic [ADDR_W-1:0]       count_addr;
   logic                    emit_last;
   logic signed [SW-1:0]    start_ext;

   assign accept = req_valid && !req_stall;

   ssah_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock  (clock),
      .load   (accept),
      .sample (req_sample),
      .result (red)
   );

   ssah_count_mem #(
      .DEPTH  (TOTAL),
      .WIDTH  (COUNT_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_addr (mem_rd_addr),
      .wr_addr (wb_addr_ff),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      zr_new   = red.zero ? ((zero_run_ff == '1) ? zero_run_ff : zero_run_ff + 1'b1) : '0;
      gap_new  = red.zero ? in_gap_ff : 1'b0;
      seg_ok   = (seg_ff >= 0) && (seg_ff < SEG_LIMIT);
      count_go = (zr_new <= silence_run_ff) && seg_ok && red.hit;
      gap_go   = (zr_new > silence_run_ff) && !gap_new;
      // segment * 10 + bin
      count_addr = ADDR_W'(ADDR_W'($unsigned(seg_ff)) * ADDR_W'(NUM_BINS)) + ADDR_W'(red.bin);
      emit_last  = (emit_addr_ff == ADDR_LAST);
      start_ext  = SW'(signed'(start_seg_ff));
      mem_wr_data = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;
   end

   always_comb begin
      state_in       = state_ff;
      silence_run_in = silence_run_ff;
      start_seg_in   = start_seg_ff;
      zero_run_in    = zero_run_ff;
      in_gap_in      = in_gap_ff;
      seg_in         = seg_ff;
      finished_in    = finished_ff;
      eos_in         = eos_ff;
      gap_emit_in    = gap_emit_ff;
      emit_addr_in   = emit_addr_ff;
      emit_seg_in    = emit_seg_ff;
      emit_bin_in    = emit_bin_ff;
      wb_addr_in     = wb_addr_ff;
      mem_cmd        = '0;
      mem_rd_addr    = emit_addr_ff;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SILENCE_RUN: begin
               silence_run_in = csr_write_data;
            end
            CSR_START_SEGMENT: begin
               start_seg_in = csr_write_data[START_W-1:0];
               seg_in       = SW'(signed'(csr_write_data[START_W-1:0]));
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               eos_in   = req_end_of_stream;
               state_in = ST_PROC;
            end
         end
         ST_PROC: begin
            state_in = ST_IDLE;
            if (finished_ff) begin
               if (eos_ff) begin
                  zero_run_in = '0;
                  in_gap_in   = 1'b0;
                  seg_in      = start_ext;
                  finished_in = 1'b0;
                  mem_cmd.clr = 1'b1;
               end
            end else begin
               zero_run_in  = zr_new;
               in_gap_in    = gap_new || gap_go;
               gap_emit_in  = 1'b0;
               emit_addr_in = '0;
               emit_seg_in  = '0;
               emit_bin_in  = '0;
               if (gap_go && (seg_ff == SEG_LAST)) begin
                  gap_emit_in = 1'b1;
                  state_in    = ST_EMIT_RD;
               end else if (gap_go) begin
                  // past the last segment the index stops moving
                  if (seg_ff < SEG_LIMIT) begin
                     seg_in = seg_ff + 1'b1;
                  end
                  if (eos_ff) begin
                     state_in = ST_EMIT_RD;
                  end
               end else if (count_go) begin
                  mem_cmd.rd  = 1'b1;
                  mem_rd_addr = count_addr;
                  wb_addr_in  = count_addr;
                  state_in    = ST_WB;
               end else if (eos_ff) begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_WB: begin
            mem_cmd.wr = 1'b1;
            state_in   = eos_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            mem_cmd.rd = 1'b1;
            state_in   = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (emit_last) begin
                  mem_cmd.clr = 1'b1;
                  state_in    = ST_IDLE;
                  if (eos_ff) begin
                     zero_run_in = '0;
                     in_gap_in   = 1'b0;
                     seg_in      = start_ext;
                     finished_in = 1'b0;
                  end else if (gap_emit_ff) begin
                     finished_in = 1'b1;
                  end
               end else begin
                  emit_addr_in = emit_addr_ff + 1'b1;
                  if (emit_bin_ff == BIN_LAST) begin
                     emit_bin_in = '0;
                     emit_seg_in = emit_seg_ff + 1'b1;
                  end else begin
                     emit_bin_in = emit_bin_ff + 1'b1;
                  end
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         silence_run_ff <= SILENCE_RESET;
         start_seg_ff   <= START_RESET;
         zero_run_ff    <= '0;
         in_gap_ff      <= 1'b0;
         seg_ff         <= SW'(signed'(START_RESET));
         finished_ff    <= 1'b0;
         eos_ff         <= 1'b0;
         gap_emit_ff    <= 1'b0;
         emit_addr_ff   <= '0;
         emit_seg_ff    <= '0;
         emit_bin_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         silence_run_ff <= silence_run_in;
         start_seg_ff   <= start_seg_in;
         zero_run_ff    <= zero_run_in;
         in_gap_ff      <= in_gap_in;
         seg_ff         <= seg_in;
         finished_ff    <= finished_in;
         eos_ff         <= eos_in;
         gap_emit_ff    <= gap_emit_in;
         emit_addr_ff   <= emit_addr_in;
         emit_seg_ff    <= emit_seg_in;
         emit_bin_ff    <= emit_bin_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
   end

   assign rsp_segment    = emit_seg_ff;
   assign rsp_bin        = emit_bin_ff;
   assign rsp_count      = mem_rd_data;
   assign rsp_last_count = emit_last;

`include "silence_segmented_amplitude_histogram_assert.svh"

   `SSAH_ASSERT_IMPL(a_no_item_while_emitting, clock, reset, rsp_valid, req_stall, "item taken during emission")
   `SSAH_ASSERT_NEXT(a_emission_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last_count, !rsp_valid, "result after the last count")
   `SSAH_ASSERT_IMPL(a_bin_in_range, clock, reset, rsp_valid, rsp_bin < BIN_W'(NUM_BINS), "bin index out of range")
   `SSAH_ASSERT_IMPL(a_write_after_read, clock, reset, mem_cmd.wr, $past(state_ff) == ST_PROC, "counter write without its read")

endmodule

`default_nettype wire
